[sv/psm_pkg.sv]
// Shared types and constants for the parallel speedup model unit.
// Holds field widths, divider geometry, function codes and the stage side-band structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

    localparam int MAX_NODES = 4096;

    localparam int FUNC_W  = 2;
    localparam int A_W     = 20;
    localparam int S_W     = 16;
    localparam int N_W     = 13;
    localparam int T_W     = 32;
    localparam int SPEED_W = 28;
    localparam int LIMIT_W = 21;

    localparam logic [FUNC_W-1:0] FUNC_SPEEDUP  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LIMIT    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PAR_TIME = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SER_TIME = 2'd3;

    // Speedup divider: dividend is the numerator with 16 fraction bits appended.
    localparam int AN_W    = A_W + N_W;
    localparam int AS_W    = A_W + S_W + 1;
    localparam int NUM1_W  = AN_W + S_W + 1;
    localparam int DEN1_W  = 39;
    localparam int Q1_W    = 29;
    localparam int DIVD1_W = NUM1_W + 16;

    // Time divider: dividend is time_in with 16 fraction bits plus rounding.
    localparam int Q2_W    = 32;
    localparam int DIVD2_W = T_W + 17;
    localparam int PROD_W  = SPEED_W + T_W;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [T_W-1:0]     t;
        logic [LIMIT_W-1:0] limit;
        logic               bypass;
        logic [SPEED_W-1:0] special;
    } side1_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [SPEED_W-1:0] sp;
        logic [LIMIT_W-1:0] limit;
        logic [T_W-1:0]     time3;
        logic               ovf;
    } side2_t;

endpackage

`default_nettype wire

[sv/parallel_speedup_model_unit.sv]
// Top level of the parallel speedup model unit: a fully pipelined evaluator.
// Depends on psm_pkg for widths, function codes and side-band structs.
// Contains the operand stages, two restoring dividers and the output register.
`timescale 1ns / 1ps
`default_nettype none

// Evaluates the piecewise Downey speedup of a job on a given node count, and from it the
// node limit, the parallel time or the serial time, selected per request by func. A new
// request is taken every cycle unless in_stall is raised; the depth comes from two
// bit-serial restoring dividers, 29 stages for the 16-bit-fraction speedup quotient and
// 32 stages for the parallel time quotient, plus operand, multiply and output stages.
// Results leave through an output register; when it is full and stalled, the pipeline
// still advances as long as its last stage holds a bubble.
module parallel_speedup_model_unit
(
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [psm_pkg::FUNC_W-1:0]       func,
    input  wire  [psm_pkg::A_W-1:0]          avg_parallelism,
    input  wire  [psm_pkg::S_W-1:0]          variance,
    input  wire  [psm_pkg::N_W-1:0]          node_count,
    input  wire  [psm_pkg::T_W-1:0]          time_in,

    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [psm_pkg::SPEED_W-1:0]      speedup_value,
    output logic [psm_pkg::LIMIT_W-1:0]      node_limit,
    output logic [psm_pkg::T_W-1:0]          time_out
);

    localparam int FUNC_W  = psm_pkg::FUNC_W;
    localparam int A_W     = psm_pkg::A_W;
    localparam int S_W     = psm_pkg::S_W;
    localparam int N_W     = psm_pkg::N_W;
    localparam int T_W     = psm_pkg::T_W;
    localparam int SPEED_W = psm_pkg::SPEED_W;
    localparam int LIMIT_W = psm_pkg::LIMIT_W;
    localparam int AN_W    = psm_pkg::AN_W;
    localparam int AS_W    = psm_pkg::AS_W;
    localparam int NUM1_W  = psm_pkg::NUM1_W;
    localparam int DEN1_W  = psm_pkg::DEN1_W;
    localparam int Q1_W    = psm_pkg::Q1_W;
    localparam int DIVD1_W = psm_pkg::DIVD1_W;
    localparam int Q2_W    = psm_pkg::Q2_W;
    localparam int DIVD2_W = psm_pkg::DIVD2_W;
    localparam int PROD_W  = psm_pkg::PROD_W;

    localparam logic [N_W-1:0]     MAX_N      = N_W'(psm_pkg::MAX_NODES);
    localparam logic [SPEED_W-1:0] SPEED_ONE  = SPEED_W'(65536);
    localparam logic [T_W-1:0]     TIME_MAX   = '1;

    logic en;

    // ------------------------------------------------------------------
    // Stage 1: clamp operands and form the first products.
    // ------------------------------------------------------------------
    logic [A_W-1:0]    a_next;
    logic [N_W-1:0]    n_next;
    logic [A_W:0]      twoa_m_next;
    logic [9:0]        m_next;
    logic [A_W+1:0]    k_next;
    logic [AN_W-1:0]   an_next;
    logic [AS_W-1:0]   as_next;
    logic [AS_W-1:0]   s2a_next;
    logic [N_W+9:0]    nm_next;
    logic [S_W+N_W-1:0] sn1_next;
    logic [S_W+A_W+1:0] sk_next;

    logic                  s1_v_reg;
    logic [FUNC_W-1:0]     s1_func_reg;
    logic [A_W-1:0]        s1_a_reg;
    logic [S_W-1:0]        s1_s_reg;
    logic [N_W-1:0]        s1_n_reg;
    logic [T_W-1:0]        s1_t_reg;
    logic [AN_W-1:0]       s1_an_reg;
    logic [AS_W-1:0]       s1_as_reg;
    logic [AS_W-1:0]       s1_s2a_reg;
    logic [N_W+9:0]        s1_nm_reg;
    logic [S_W+N_W-1:0]    s1_sn1_reg;
    logic [S_W+A_W+1:0]    s1_sk_reg;

    always_comb
    begin
        a_next = (avg_parallelism < A_W'(256)) ? A_W'(256) : avg_parallelism;
        if (node_count == '0)
            n_next = N_W'(1);
        else if (node_count > MAX_N)
            n_next = MAX_N;
        else
            n_next = node_count;
        twoa_m_next = {a_next, 1'b0} - (A_W+1)'(256);
        // Only meaningful when the variance is at most one.
        m_next      = 10'd512 - variance[9:0];
        k_next      = (A_W+2)'({n_next, 8'd0}) + (A_W+2)'(a_next) - (A_W+2)'(256);
        an_next     = AN_W'(a_next) * AN_W'(n_next);
        as_next     = AS_W'(a_next) * AS_W'((S_W+1)'(variance) + (S_W+1)'(256));
        s2a_next    = AS_W'(variance) * AS_W'(twoa_m_next);
        nm_next     = (N_W+10)'(n_next) * (N_W+10)'(m_next);
        sn1_next    = (S_W+N_W)'(variance) * (S_W+N_W)'(n_next - N_W'(1));
        sk_next     = (S_W+A_W+2)'(variance) * (S_W+A_W+2)'(k_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_func_reg <= func;
            s1_a_reg    <= a_next;
            s1_s_reg    <= variance;
            s1_n_reg    <= n_next;
            s1_t_reg    <= time_in;
            s1_an_reg   <= an_next;
            s1_as_reg   <= as_next;
            s1_s2a_reg  <= s2a_next;
            s1_nm_reg   <= nm_next;
            s1_sn1_reg  <= sn1_next;
            s1_sk_reg   <= sk_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: region tests, denominators, node limit, third numerator.
    // ------------------------------------------------------------------
    logic [AS_W-1:0]    bound_next;
    logic [AS_W:0]      lim_sum_next;
    logic [A_W:0]       lim_small_next;
    logic [LIMIT_W-1:0] limit_next;
    logic               r1_next;
    logic               r2_next;
    logic               r3_next;
    logic [NUM1_W-1:0]  num3_next;
    logic [DEN1_W-1:0]  den1_next;
    logic [DEN1_W-1:0]  den2_next;
    logic [DEN1_W-1:0]  den3_next;

    logic                  s2_v_reg;
    logic [FUNC_W-1:0]     s2_func_reg;
    logic [A_W-1:0]        s2_a_reg;
    logic [T_W-1:0]        s2_t_reg;
    logic [AN_W-1:0]       s2_an_reg;
    logic [NUM1_W-1:0]     s2_num3_reg;
    logic [DEN1_W-1:0]     s2_den1_reg;
    logic [DEN1_W-1:0]     s2_den2_reg;
    logic [DEN1_W-1:0]     s2_den3_reg;
    logic                  s2_r1_reg;
    logic                  s2_r2_reg;
    logic                  s2_r3_reg;
    logic                  s2_small_reg;
    logic                  s2_one_reg;
    logic [LIMIT_W-1:0]    s2_limit_reg;

    always_comb
    begin
        bound_next     = s1_as_reg - AS_W'({s1_s_reg, 8'd0});
        lim_sum_next   = (AS_W+1)'(bound_next) + (AS_W+1)'(65535);
        lim_small_next = {s1_a_reg, 1'b0} - (A_W+1)'(1);
        if (s1_s_reg <= S_W'(256))
            limit_next = LIMIT_W'(lim_small_next[A_W:8]);
        else
            limit_next = lim_sum_next[LIMIT_W+15:16];
        r1_next   = (A_W+1)'({s1_n_reg, 8'd0}) <= (A_W+1)'(s1_a_reg);
        r2_next   = (A_W+2)'({s1_n_reg, 8'd0}) + (A_W+2)'(256)
                    <= (A_W+2)'({s1_a_reg, 1'b0});
        r3_next   = AS_W'({s1_n_reg, 16'd0}) <= bound_next;
        num3_next = NUM1_W'(s1_an_reg) * NUM1_W'((S_W+1)'(s1_s_reg) + (S_W+1)'(256));
        den1_next = DEN1_W'({s1_a_reg, 1'b0}) + DEN1_W'(s1_sn1_reg);
        den2_next = DEN1_W'(s1_s2a_reg) + DEN1_W'({s1_nm_reg, 8'd0});
        den3_next = DEN1_W'(s1_sk_reg) + DEN1_W'({s1_a_reg, 8'd0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_func_reg  <= s1_func_reg;
            s2_a_reg     <= s1_a_reg;
            s2_t_reg     <= s1_t_reg;
            s2_an_reg    <= s1_an_reg;
            s2_num3_reg  <= num3_next;
            s2_den1_reg  <= den1_next;
            s2_den2_reg  <= den2_next;
            s2_den3_reg  <= den3_next;
            s2_r1_reg    <= r1_next;
            s2_r2_reg    <= r2_next;
            s2_r3_reg    <= r3_next;
            s2_small_reg <= (s1_s_reg <= S_W'(256));
            s2_one_reg   <= (s1_n_reg == N_W'(1));
            s2_limit_reg <= limit_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 and speedup divider: pick the region, then one quotient bit
    // per stage. Index 0 holds the divider operands.
    // ------------------------------------------------------------------
    logic [NUM1_W-1:0]  num_next;
    logic [DEN1_W-1:0]  den_next;
    logic [DIVD1_W-1:0] divd1_next;
    psm_pkg::side1_t    side1_next;

    logic                    d1_v_reg    [0:Q1_W];
    logic [DEN1_W-1:0]       d1_rem_reg  [0:Q1_W];
    logic [Q1_W-1:0]         d1_ql_reg   [0:Q1_W];
    logic [DEN1_W-1:0]       d1_den_reg  [0:Q1_W];
    psm_pkg::side1_t         d1_side_reg [0:Q1_W];

    always_comb
    begin
        num_next           = '0;
        den_next           = DEN1_W'(1);
        side1_next.func    = s2_func_reg;
        side1_next.t       = s2_t_reg;
        side1_next.limit   = s2_limit_reg;
        side1_next.bypass  = 1'b1;
        side1_next.special = SPEED_W'({s2_a_reg, 8'd0});
        if (s2_one_reg)
        begin
            side1_next.special = SPEED_ONE;
        end
        else if (s2_small_reg)
        begin
            if (s2_r1_reg)
            begin
                side1_next.bypass = 1'b0;
                num_next          = NUM1_W'({s2_an_reg, 1'b0});
                den_next          = s2_den1_reg;
            end
            else if (s2_r2_reg)
            begin
                side1_next.bypass = 1'b0;
                num_next          = NUM1_W'({s2_an_reg, 9'd0});
                den_next          = s2_den2_reg;
            end
        end
        else if (s2_r3_reg)
        begin
            side1_next.bypass = 1'b0;
            num_next          = s2_num3_reg;
            den_next          = s2_den3_reg;
        end
        divd1_next = {num_next, 16'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_v_reg[0] <= 1'b0;
        else if (en)
            d1_v_reg[0] <= s2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_rem_reg[0]  <= DEN1_W'(divd1_next[DIVD1_W-1:Q1_W]);
            d1_ql_reg[0]   <= divd1_next[Q1_W-1:0];
            d1_den_reg[0]  <= den_next;
            d1_side_reg[0] <= side1_next;
        end
    end

    for (genvar i = 0; i < Q1_W; i++)
    begin : g_div1
        logic [DEN1_W:0]   trial;
        logic              ge;
        logic [DEN1_W-1:0] rem_next;
        logic [Q1_W-1:0]   ql_next;

        // The partial remainder stays below the divisor, so the trial fits.
        always_comb
        begin
            trial    = {d1_rem_reg[i], d1_ql_reg[i][Q1_W-1]};
            ge       = trial >= {1'b0, d1_den_reg[i]};
            rem_next = ge ? DEN1_W'(trial - {1'b0, d1_den_reg[i]}) : DEN1_W'(trial);
            ql_next  = {d1_ql_reg[i][Q1_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d1_v_reg[i+1] <= 1'b0;
            else if (en)
                d1_v_reg[i+1] <= d1_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d1_rem_reg[i+1]  <= rem_next;
                d1_ql_reg[i+1]   <= ql_next;
                d1_den_reg[i+1]  <= d1_den_reg[i];
                d1_side_reg[i+1] <= d1_side_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Post stage: final speedup, serial-time product, rounded dividend.
    // ------------------------------------------------------------------
    psm_pkg::side1_t    side1_end;
    logic [SPEED_W-1:0] sp_next;
    logic [PROD_W-1:0]  prod_next;
    logic [DIVD2_W-1:0] n2_next;

    logic                  p_v_reg;
    logic [FUNC_W-1:0]     p_func_reg;
    logic [SPEED_W-1:0]    p_sp_reg;
    logic [LIMIT_W-1:0]    p_limit_reg;
    logic [PROD_W-1:0]     p_prod_reg;
    logic [DIVD2_W-1:0]    p_n2_reg;

    always_comb
    begin
        side1_end = d1_side_reg[Q1_W];
        sp_next   = side1_end.bypass ? side1_end.special : d1_ql_reg[Q1_W][SPEED_W-1:0];
        prod_next = PROD_W'(sp_next) * PROD_W'(side1_end.t);
        // A zero speedup can wrap here; the overflow test below catches it.
        n2_next   = DIVD2_W'({side1_end.t, 16'd0}) + DIVD2_W'(sp_next) - DIVD2_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else if (en)
            p_v_reg <= d1_v_reg[Q1_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_func_reg  <= side1_end.func;
            p_sp_reg    <= sp_next;
            p_limit_reg <= side1_end.limit;
            p_prod_reg  <= prod_next;
            p_n2_reg    <= n2_next;
        end
    end

    // ------------------------------------------------------------------
    // Time divider: overflow test and serial time at index 0, then one
    // quotient bit per stage.
    // ------------------------------------------------------------------
    logic [PROD_W:0]       ser_sum_next;
    logic [PROD_W-16:0]    ser_q_next;
    psm_pkg::side2_t       side2_next;

    logic                    d2_v_reg    [0:Q2_W];
    logic [SPEED_W-1:0]      d2_rem_reg  [0:Q2_W];
    logic [Q2_W-1:0]         d2_ql_reg   [0:Q2_W];
    logic [SPEED_W-1:0]      d2_den_reg  [0:Q2_W];
    psm_pkg::side2_t         d2_side_reg [0:Q2_W];

    always_comb
    begin
        ser_sum_next     = (PROD_W+1)'(p_prod_reg) + (PROD_W+1)'(65535);
        ser_q_next       = ser_sum_next[PROD_W:16];
        side2_next.func  = p_func_reg;
        side2_next.sp    = p_sp_reg;
        side2_next.limit = p_limit_reg;
        if (ser_q_next == '0)
            side2_next.time3 = T_W'(1);
        else if (ser_q_next > (PROD_W-15)'(TIME_MAX))
            side2_next.time3 = TIME_MAX;
        else
            side2_next.time3 = ser_q_next[T_W-1:0];
        // Quotient would reach 2^32 or the speedup is zero: saturate.
        side2_next.ovf = SPEED_W'(p_n2_reg[DIVD2_W-1:Q2_W]) >= p_sp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d2_v_reg[0] <= 1'b0;
        else if (en)
            d2_v_reg[0] <= p_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_rem_reg[0]  <= SPEED_W'(p_n2_reg[DIVD2_W-1:Q2_W]);
            d2_ql_reg[0]   <= p_n2_reg[Q2_W-1:0];
            d2_den_reg[0]  <= p_sp_reg;
            d2_side_reg[0] <= side2_next;
        end
    end

    for (genvar j = 0; j < Q2_W; j++)
    begin : g_div2
        logic [SPEED_W:0]   trial;
        logic               ge;
        logic [SPEED_W-1:0] rem_next;
        logic [Q2_W-1:0]    ql_next;

        always_comb
        begin
            trial    = {d2_rem_reg[j], d2_ql_reg[j][Q2_W-1]};
            ge       = trial >= {1'b0, d2_den_reg[j]};
            rem_next = ge ? SPEED_W'(trial - {1'b0, d2_den_reg[j]}) : SPEED_W'(trial);
            ql_next  = {d2_ql_reg[j][Q2_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d2_v_reg[j+1] <= 1'b0;
            else if (en)
                d2_v_reg[j+1] <= d2_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d2_rem_reg[j+1]  <= rem_next;
                d2_ql_reg[j+1]   <= ql_next;
                d2_den_reg[j+1]  <= d2_den_reg[j];
                d2_side_reg[j+1] <= d2_side_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    psm_pkg::side2_t    side2_end;
    logic [T_W-1:0]     par_time_next;
    logic [SPEED_W-1:0] speed_next;
    logic [LIMIT_W-1:0] limit_out_next;
    logic [T_W-1:0]     time_next;

    logic               out_valid_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [T_W-1:0]     time_reg;

    always_comb
    begin
        side2_end = d2_side_reg[Q2_W];
        if (side2_end.ovf)
            par_time_next = TIME_MAX;
        else if (d2_ql_reg[Q2_W] == '0)
            par_time_next = T_W'(1);
        else
            par_time_next = d2_ql_reg[Q2_W];
        speed_next     = '0;
        limit_out_next = '0;
        time_next      = '0;
        case (side2_end.func)
            psm_pkg::FUNC_SPEEDUP:  speed_next     = side2_end.sp;
            psm_pkg::FUNC_LIMIT:    limit_out_next = side2_end.limit;
            psm_pkg::FUNC_PAR_TIME: time_next      = par_time_next;
            psm_pkg::FUNC_SER_TIME: time_next      = side2_end.time3;
            default:                time_next      = '0;
        endcase
    end

    // The pipeline moves unless a full output register is stalled behind a
    // valid last stage; a bubble in that stage is simply squeezed out.
    assign en = !out_valid_reg || !out_stall || !d2_v_reg[Q2_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || !out_stall)
            out_valid_reg <= d2_v_reg[Q2_W];
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            speed_reg <= speed_next;
            limit_reg <= limit_out_next;
            time_reg  <= time_next;
        end
    end

    assign in_stall      = !en;
    assign out_valid     = out_valid_reg;
    assign speedup_value = speed_reg;
    assign node_limit    = limit_reg;
    assign time_out      = time_reg;

endmodule

`default_nettype wire
